### rtl/core/gest_pkg.sv
// Package for the generational entity slot table.
// Holds the request and response word types, request and status codes,
// the command word passed from the front end to the back end, and state types.
package gest_pkg;

    localparam logic [2:0] REQ_ALLOC = 3'd0;
    localparam logic [2:0] REQ_FREE  = 3'd1;
    localparam logic [2:0] REQ_SET   = 3'd2;
    localparam logic [2:0] REQ_CLEAR = 3'd3;
    localparam logic [2:0] REQ_TEST  = 3'd4;
    localparam logic [2:0] REQ_CHECK = 3'd5;
    localparam logic [2:0] REQ_MATCH = 3'd6;

    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_EMPTY = 2'd1;
    localparam logic [1:0] STS_STALE = 2'd2;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [5:0]  handle_index;
        logic [7:0]  handle_gen;
        logic [4:0]  comp_id;
        logic [31:0] query_mask;
    } t_req_word;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] out_index;
        logic [7:0] out_gen;
        logic       flag;
        logic       last;
    } t_rsp_word;

    typedef enum logic [2:0] {
        CMD_ALLOC,
        CMD_FREE,
        CMD_SET,
        CMD_CLEAR,
        CMD_TEST,
        CMD_CHECK,
        CMD_MATCH,
        CMD_NOP
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op     op;
        logic        idx_ok;
        logic [5:0]  index;
        logic [7:0]  gen;
        logic [4:0]  comp_id;
        logic [31:0] mask;
    } t_cmd;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_AREAD,
        BK_EXEC,
        BK_SCAN,
        BK_DONE
    } t_back_state;

endpackage

### rtl/core/generational_entity_slot_table.sv
// Top level of the generational entity slot table.
// Instantiates gest_front, gest_cmd_queue and gest_back; uses gest_pkg.
//
//   Channel   Valid        Stall        Word
//   request   i_in_valid   o_in_stall   i_in_word  (gest_pkg::t_req_word)
//   response  o_out_valid  i_out_stall  o_out_word (gest_pkg::t_rsp_word)
//
// Free, set, clear, test and check go from idle to execute; allocate first
// reads the free stack, as the generation read waits on it. A match scans
// one slot per cycle, unless an output stall holds a pending hit, through
// the single slot-memory read port, and emits one word per hit, or one word
// if none hit. Output stalls hold the back end; the two-entry queue keeps
// taking requests. Reset, synchronous and active low, needs no clearing pass.
module generational_entity_slot_table #(
    parameter int ENTITY_SLOTS   = 64,
    parameter int COMPONENT_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  gest_pkg::t_req_word i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output gest_pkg::t_rsp_word o_out_word
);

    logic           push;
    logic           q_full;
    logic           q_valid;
    logic           q_pop;
    gest_pkg::t_cmd front_cmd;
    gest_pkg::t_cmd q_cmd;

    gest_front #(
        .ENTITY_SLOTS(ENTITY_SLOTS)
    ) u_front (
        .i_in_valid (i_in_valid),
        .i_in_word  (i_in_word),
        .i_q_full   (q_full),
        .o_in_stall (o_in_stall),
        .o_push     (push),
        .o_cmd      (front_cmd)
    );

    gest_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    gest_back #(
        .ENTITY_SLOTS   (ENTITY_SLOTS),
        .COMPONENT_BITS (COMPONENT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_stall (i_out_stall)
    );

endmodule

### rtl/core/gest_front.sv
// Front end of the slot table: accepts request words and classifies them.
// Uses gest_pkg for the request word and command types.
module gest_front #(
    parameter int ENTITY_SLOTS = 64
) (
    input  logic                i_in_valid,
    input  gest_pkg::t_req_word i_in_word,
    input  logic                i_q_full,
    output logic                o_in_stall,
    output logic                o_push,
    output gest_pkg::t_cmd      o_cmd
);

    gest_pkg::t_cmd_op op;

    always_comb begin
        unique case (i_in_word.req_type)
            gest_pkg::REQ_ALLOC: op = gest_pkg::CMD_ALLOC;
            gest_pkg::REQ_FREE:  op = gest_pkg::CMD_FREE;
            gest_pkg::REQ_SET:   op = gest_pkg::CMD_SET;
            gest_pkg::REQ_CLEAR: op = gest_pkg::CMD_CLEAR;
            gest_pkg::REQ_TEST:  op = gest_pkg::CMD_TEST;
            gest_pkg::REQ_CHECK: op = gest_pkg::CMD_CHECK;
            gest_pkg::REQ_MATCH: op = gest_pkg::CMD_MATCH;
            default:             op = gest_pkg::CMD_NOP;
        endcase
    end

    always_comb begin
        o_cmd.op      = op;
        // A handle beyond the table never validates.
        o_cmd.idx_ok  = ({1'b0, i_in_word.handle_index} < 7'(ENTITY_SLOTS));
        o_cmd.index   = i_in_word.handle_index;
        o_cmd.gen     = i_in_word.handle_gen;
        o_cmd.comp_id = i_in_word.comp_id;
        o_cmd.mask    = i_in_word.query_mask;
    end

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid & ~i_q_full;

endmodule

### rtl/core/gest_cmd_queue.sv
// Two-entry command queue between the front end and the back end.
// Uses gest_pkg for the command type.
module gest_cmd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  gest_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output gest_pkg::t_cmd o_cmd
);

    gest_pkg::t_cmd r_mem [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

### rtl/core/gest_back.sv
// Back end of the slot table: slot memories, free stack, match scan and
// the output register. Uses gest_pkg for command, response and state types.
module gest_back #(
    parameter int ENTITY_SLOTS   = 64,
    parameter int COMPONENT_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  gest_pkg::t_cmd      i_q_cmd,
    output logic                o_q_pop,
    output logic                o_out_valid,
    output gest_pkg::t_rsp_word o_out_word,
    input  logic                i_out_stall
);

    localparam int SW   = $clog2(ENTITY_SLOTS);
    localparam int CNTW = $clog2(ENTITY_SLOTS + 1);
    localparam int CB   = COMPONENT_BITS;
    localparam logic [CNTW-1:0] SLOTS_C   = CNTW'(ENTITY_SLOTS);
    localparam logic [CNTW-1:0] LAST_C    = CNTW'(ENTITY_SLOTS - 1);
    localparam logic [SW-1:0]   LAST_SLOT = SW'(ENTITY_SLOTS - 1);

    // Slot memories and free stack.
    logic [7:0]    r_gen_mem  [ENTITY_SLOTS];
    logic [CB-1:0] r_comp_mem [ENTITY_SLOTS];
    logic [SW-1:0] r_stk_mem  [ENTITY_SLOTS];

    logic [ENTITY_SLOTS-1:0] r_in_use;
    logic [ENTITY_SLOTS-1:0] r_gen_vld;

    logic [CNTW-1:0] r_free_cnt, n_free_cnt;
    logic [CNTW-1:0] r_stk_low, n_stk_low;

    gest_pkg::t_back_state r_state, n_state;
    gest_pkg::t_cmd        r_cmd;

    logic [SW-1:0] r_alloc_slot;
    logic [SW-1:0] r_scan, n_scan;
    logic          r_pend_vld, n_pend_vld;
    logic [SW-1:0] r_pend_idx, n_pend_idx;
    logic [7:0]    r_pend_gen, n_pend_gen;

    logic                r_out_vld, n_out_vld;
    gest_pkg::t_rsp_word r_out_word, n_out_word;

    // Registered read data.
    logic [7:0]    r_rd_gen;
    logic [CB-1:0] r_rd_comp;
    logic          r_rd_used;
    logic          r_rd_gvld;
    logic [SW-1:0] r_rd_stk;
    logic          r_rd_stk_dflt;

    logic          rd_en;
    logic [SW-1:0] rd_addr;
    logic          stk_rd_en;
    logic [CNTW-1:0] cnt_m1;
    logic [CNTW-1:0] dflt_pos;
    logic [SW-1:0] alloc_slot_c;
    logic [SW-1:0] cmd_slot;
    logic [7:0]    gen_val;
    logic          handle_ok;
    logic [CB-1:0] comp_bit;
    logic [CB-1:0] mask_cb;
    logic [31:0]   comp_q32;
    logic          hit;
    logic          out_free;

    logic          gen_we;
    logic [7:0]    gen_wdata;
    logic          comp_we;
    logic [SW-1:0] comp_waddr;
    logic [CB-1:0] comp_wdata;
    logic          stk_we;
    logic          use_set;
    logic          use_clr;
    logic [SW-1:0] use_addr;
    logic          emit;
    gest_pkg::t_rsp_word rsp;

    // Components widened or cut to the 32-bit query width, and the query
    // mask fitted to the component width.
    for (genvar gi = 0; gi < 32; gi++) begin : g_q32
        if (gi < CB) begin : g_in
            assign comp_q32[gi] = r_rd_comp[gi];
        end else begin : g_out
            assign comp_q32[gi] = 1'b0;
        end
    end

    for (genvar gj = 0; gj < CB; gj++) begin : g_mcb
        if (gj < 32) begin : g_in
            assign mask_cb[gj] = r_cmd.mask[gj];
        end else begin : g_out
            assign mask_cb[gj] = 1'b0;
        end
    end

    assign cmd_slot     = r_cmd.index[SW-1:0];
    assign cnt_m1       = r_free_cnt - CNTW'(1);
    assign dflt_pos     = LAST_C - cnt_m1;
    // Stack entries below the lowest fill level ever reached have never been
    // written, so their reset contents are computed instead.
    assign alloc_slot_c = r_rd_stk_dflt ? dflt_pos[SW-1:0] : r_rd_stk;
    assign gen_val      = r_rd_gvld ? r_rd_gen : 8'd0;
    assign handle_ok    = r_cmd.idx_ok & r_rd_used & (gen_val == r_cmd.gen);
    assign comp_bit     = CB'(1) << r_cmd.comp_id;
    assign hit          = r_rd_used & ((comp_q32 & r_cmd.mask) == r_cmd.mask);
    assign out_free     = ~r_out_vld | ~i_out_stall;

    always_comb begin
        n_state    = r_state;
        o_q_pop    = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = cmd_slot;
        stk_rd_en  = 1'b0;
        n_free_cnt = r_free_cnt;
        n_stk_low  = r_stk_low;
        n_scan     = r_scan;
        n_pend_vld = r_pend_vld;
        n_pend_idx = r_pend_idx;
        n_pend_gen = r_pend_gen;
        gen_we     = 1'b0;
        gen_wdata  = gen_val + 8'd1;
        comp_we    = 1'b0;
        comp_waddr = cmd_slot;
        comp_wdata = mask_cb;
        stk_we     = 1'b0;
        use_set    = 1'b0;
        use_clr    = 1'b0;
        use_addr   = cmd_slot;
        emit       = 1'b0;
        rsp        = '0;
        rsp.status = gest_pkg::STS_OK;
        rsp.last   = 1'b1;

        unique case (r_state)
            gest_pkg::BK_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop   = 1'b1;
                    rd_en     = 1'b1;
                    rd_addr   = i_q_cmd.index[SW-1:0];
                    stk_rd_en = (r_free_cnt != '0);
                    if (i_q_cmd.op == gest_pkg::CMD_MATCH) begin
                        rd_addr    = '0;
                        n_scan     = '0;
                        n_pend_vld = 1'b0;
                        n_state    = gest_pkg::BK_SCAN;
                    end else if (i_q_cmd.op == gest_pkg::CMD_ALLOC) begin
                        n_state = gest_pkg::BK_AREAD;
                    end else begin
                        n_state = gest_pkg::BK_EXEC;
                    end
                end
            end
            gest_pkg::BK_AREAD: begin
                rd_en   = 1'b1;
                rd_addr = alloc_slot_c;
                n_state = gest_pkg::BK_EXEC;
            end
            gest_pkg::BK_EXEC: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = gest_pkg::BK_IDLE;
                    unique case (r_cmd.op)
                        gest_pkg::CMD_ALLOC: begin
                            if (r_free_cnt == '0) begin
                                rsp.status = gest_pkg::STS_EMPTY;
                            end else begin
                                n_free_cnt = cnt_m1;
                                if (cnt_m1 < r_stk_low) begin
                                    n_stk_low = cnt_m1;
                                end
                                use_set       = 1'b1;
                                use_addr      = r_alloc_slot;
                                comp_we       = 1'b1;
                                comp_waddr    = r_alloc_slot;
                                comp_wdata    = mask_cb;
                                rsp.out_index = 6'(r_alloc_slot);
                                rsp.out_gen   = gen_val;
                                rsp.flag      = 1'b1;
                            end
                        end
                        gest_pkg::CMD_FREE: begin
                            if (!handle_ok) begin
                                rsp.status = gest_pkg::STS_STALE;
                            end else begin
                                gen_we  = 1'b1;
                                use_clr = 1'b1;
                                if (r_free_cnt < SLOTS_C) begin
                                    stk_we     = 1'b1;
                                    n_free_cnt = r_free_cnt + CNTW'(1);
                                end
                            end
                        end
                        gest_pkg::CMD_SET, gest_pkg::CMD_CLEAR: begin
                            if (!handle_ok) begin
                                rsp.status = gest_pkg::STS_STALE;
                            end else begin
                                comp_we    = 1'b1;
                                comp_wdata = (r_cmd.op == gest_pkg::CMD_SET) ?
                                             (r_rd_comp | comp_bit) :
                                             (r_rd_comp & ~comp_bit);
                            end
                        end
                        gest_pkg::CMD_TEST: begin
                            if (!handle_ok) begin
                                rsp.status = gest_pkg::STS_STALE;
                            end else begin
                                rsp.flag = |(r_rd_comp & comp_bit);
                            end
                        end
                        gest_pkg::CMD_CHECK: begin
                            rsp.flag = handle_ok;
                        end
                        gest_pkg::CMD_MATCH, gest_pkg::CMD_NOP: begin
                            rsp.flag = 1'b0;
                        end
                    endcase
                end
            end
            gest_pkg::BK_SCAN: begin
                // A hit is held back until the next hit or the end of the
                // scan, so that the final word can carry last.
                if (!(hit && r_pend_vld && !out_free)) begin
                    if (hit && r_pend_vld) begin
                        emit          = 1'b1;
                        rsp.out_index = 6'(r_pend_idx);
                        rsp.out_gen   = r_pend_gen;
                        rsp.flag      = 1'b1;
                        rsp.last      = 1'b0;
                    end
                    if (hit) begin
                        n_pend_vld = 1'b1;
                        n_pend_idx = r_scan;
                        n_pend_gen = gen_val;
                    end
                    if (r_scan == LAST_SLOT) begin
                        n_state = gest_pkg::BK_DONE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = r_scan + SW'(1);
                        n_scan  = r_scan + SW'(1);
                    end
                end
            end
            gest_pkg::BK_DONE: begin
                if (out_free) begin
                    emit       = 1'b1;
                    n_pend_vld = 1'b0;
                    n_state    = gest_pkg::BK_IDLE;
                    if (r_pend_vld) begin
                        rsp.out_index = 6'(r_pend_idx);
                        rsp.out_gen   = r_pend_gen;
                        rsp.flag      = 1'b1;
                    end
                end
            end
        endcase

        n_out_vld  = r_out_vld & i_out_stall;
        n_out_word = r_out_word;
        if (emit) begin
            n_out_vld  = 1'b1;
            n_out_word = rsp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= gest_pkg::BK_IDLE;
            r_free_cnt <= SLOTS_C;
            r_stk_low  <= SLOTS_C;
            r_in_use   <= '0;
            r_gen_vld  <= '0;
            r_out_vld  <= 1'b0;
            r_pend_vld <= 1'b0;
            r_scan     <= '0;
        end else begin
            r_state    <= n_state;
            r_free_cnt <= n_free_cnt;
            r_stk_low  <= n_stk_low;
            r_out_vld  <= n_out_vld;
            r_pend_vld <= n_pend_vld;
            r_scan     <= n_scan;
            if (use_set) begin
                r_in_use[use_addr] <= 1'b1;
            end
            if (use_clr) begin
                r_in_use[use_addr] <= 1'b0;
            end
            if (gen_we) begin
                r_gen_vld[cmd_slot] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_word <= n_out_word;
        r_pend_idx <= n_pend_idx;
        r_pend_gen <= n_pend_gen;
        if (o_q_pop) begin
            r_cmd <= i_q_cmd;
        end
        if (r_state == gest_pkg::BK_AREAD) begin
            r_alloc_slot <= alloc_slot_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (gen_we) begin
            r_gen_mem[cmd_slot] <= gen_wdata;
        end
        if (comp_we) begin
            r_comp_mem[comp_waddr] <= comp_wdata;
        end
        if (stk_we) begin
            r_stk_mem[r_free_cnt[SW-1:0]] <= cmd_slot;
        end
        if (rd_en) begin
            r_rd_gen  <= r_gen_mem[rd_addr];
            r_rd_comp <= r_comp_mem[rd_addr];
            r_rd_used <= r_in_use[rd_addr];
            r_rd_gvld <= r_gen_vld[rd_addr];
        end
        if (stk_rd_en) begin
            r_rd_stk      <= r_stk_mem[cnt_m1[SW-1:0]];
            r_rd_stk_dflt <= (cnt_m1 < r_stk_low);
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out_word;

endmodule

### rtl/core/gest_checker.sv
// Port-level checks for the generational entity slot table.
// Uses gest_pkg; bound to generational_entity_slot_table below.
module gest_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input gest_pkg::t_req_word i_in_word,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input gest_pkg::t_rsp_word o_out_word
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("response valid right after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("stalled response word changed");

    a_in_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_word))
        else $error("stalled request word changed");

    // Only a match hit is followed by more words of the same request.
    a_not_last_is_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.last |->
            o_out_word.flag && o_out_word.status == gest_pkg::STS_OK)
        else $error("non-final word that is not a match hit");

    a_error_word_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.status != gest_pkg::STS_OK |->
            !o_out_word.flag && o_out_word.last && o_out_word.out_index == 6'd0 &&
            o_out_word.out_gen == 8'd0)
        else $error("error word carries data");

endmodule

bind generational_entity_slot_table gest_checker u_gest_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

### tb/sv/generational_entity_slot_table_test.sv
// Self-checking testbench for generational_entity_slot_table: directed, pool,
// generation-reuse and random tests, with a slot-table predictor in the bench.
// Depends on gest_pkg and the generational_entity_slot_table RTL.
module generational_entity_slot_table_test;
    import gest_pkg::*;

    localparam int ENTITY_SLOTS   = 64;
    localparam int COMPONENT_BITS = 32;
    localparam logic [2:0] REQ_UNUSED = 3'd7;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       in_valid = 1'b0;
    t_req_word  in_word = '0;
    logic       in_stall;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_rsp_word  out_word;

    generational_entity_slot_table #(
        .ENTITY_SLOTS  (ENTITY_SLOTS),
        .COMPONENT_BITS(COMPONENT_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_word  (in_word),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_word (out_word)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predicted copy of the slot table.
    logic [5:0]  free_slots [ENTITY_SLOTS];
    int          free_depth;
    logic [7:0]  slot_gen   [ENTITY_SLOTS];
    logic [31:0] slot_comps [ENTITY_SLOTS];
    logic        slot_busy  [ENTITY_SLOTS];

    t_rsp_word   pending_responses [$];
    int          mismatch_count = 0;

    int          send_gap = 0;
    bit          valid_held = 1'b0;
    bit          send_burst = 1'b0;
    bit          recv_burst = 1'b0;
    int          stall_left = 0;

    function automatic int draw_wait(inout bit burst);
        if ($urandom_range(0, 15) == 0)
            burst = !burst;
        return burst ? 0 : $urandom_range(0, 16);
    endfunction

    function automatic t_req_word req_word(input logic [2:0] req, input logic [5:0] idx,
                                           input logic [7:0] gen, input logic [4:0] comp,
                                           input logic [31:0] mask);
        t_req_word w;
        w.req_type     = req;
        w.handle_index = idx;
        w.handle_gen   = gen;
        w.comp_id      = comp;
        w.query_mask   = mask;
        return w;
    endfunction

    function automatic logic [31:0] rand_mask();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'hFFFF_FFFF;
            2: return (32'd1 << $urandom_range(0, 31)) | (32'd1 << $urandom_range(0, 31));
            default: return $urandom & $urandom & $urandom;
        endcase
    endfunction

    function automatic int live_count();
        int n;
        n = 0;
        for (int i = 0; i < ENTITY_SLOTS; i++)
            if (slot_busy[i])
                n++;
        return n;
    endfunction

    function automatic int pick_live_slot();
        int live [$];
        for (int i = 0; i < ENTITY_SLOTS; i++)
            if (slot_busy[i])
                live.push_back(i);
        if (live.size() == 0)
            return -1;
        return live[$urandom_range(0, live.size() - 1)];
    endfunction

    task automatic reset_slot_table();
        for (int i = 0; i < ENTITY_SLOTS; i++) begin
            free_slots[i] = 6'(ENTITY_SLOTS - 1 - i);
            slot_gen[i]   = '0;
            slot_comps[i] = '0;
            slot_busy[i]  = 1'b0;
        end
        free_depth = ENTITY_SLOTS;
    endtask

    task automatic expect_rsp(input logic [1:0] st, input logic [5:0] idx,
                              input logic [7:0] gen, input logic flag, input logic last);
        t_rsp_word r;
        r.status    = st;
        r.out_index = idx;
        r.out_gen   = gen;
        r.flag      = flag;
        r.last      = last;
        pending_responses.push_back(r);
    endtask

    // Applies one accepted request word to the predicted table.
    task automatic predict_slot_table(input t_req_word w);
        logic        valid;
        logic [5:0]  s;
        logic [5:0]  hi;
        logic [31:0] comp_bit;
        int          last_hit;
        hi = w.handle_index;
        valid = slot_busy[hi] && slot_gen[hi] == w.handle_gen;
        comp_bit = (w.comp_id < COMPONENT_BITS) ? (32'd1 << w.comp_id) : 32'd0;
        case (w.req_type)
            REQ_ALLOC: begin
                if (free_depth == 0) begin
                    expect_rsp(STS_EMPTY, '0, '0, 1'b0, 1'b1);
                end else begin
                    free_depth--;
                    s = free_slots[free_depth];
                    slot_busy[s]  = 1'b1;
                    slot_comps[s] = w.query_mask;
                    expect_rsp(STS_OK, s, slot_gen[s], 1'b1, 1'b1);
                end
            end
            REQ_FREE: begin
                if (!valid) begin
                    expect_rsp(STS_STALE, '0, '0, 1'b0, 1'b1);
                end else begin
                    slot_gen[hi]   = slot_gen[hi] + 8'd1;
                    slot_comps[hi] = '0;
                    slot_busy[hi]  = 1'b0;
                    if (free_depth < ENTITY_SLOTS) begin
                        free_slots[free_depth] = hi;
                        free_depth++;
                    end
                    expect_rsp(STS_OK, '0, '0, 1'b0, 1'b1);
                end
            end
            REQ_SET, REQ_CLEAR, REQ_TEST: begin
                if (!valid) begin
                    expect_rsp(STS_STALE, '0, '0, 1'b0, 1'b1);
                end else begin
                    if (w.req_type == REQ_SET)
                        slot_comps[hi] = slot_comps[hi] | comp_bit;
                    else if (w.req_type == REQ_CLEAR)
                        slot_comps[hi] = slot_comps[hi] & ~comp_bit;
                    expect_rsp(STS_OK, '0, '0,
                               w.req_type == REQ_TEST && (slot_comps[hi] & comp_bit) != 0,
                               1'b1);
                end
            end
            REQ_CHECK: expect_rsp(STS_OK, '0, '0, valid, 1'b1);
            REQ_MATCH: begin
                last_hit = -1;
                for (int i = 0; i < ENTITY_SLOTS; i++)
                    if (slot_busy[i] && (slot_comps[i] & w.query_mask) == w.query_mask)
                        last_hit = i;
                if (last_hit < 0)
                    expect_rsp(STS_OK, '0, '0, 1'b0, 1'b1);
                for (int i = 0; i <= last_hit; i++)
                    if (slot_busy[i] && (slot_comps[i] & w.query_mask) == w.query_mask)
                        expect_rsp(STS_OK, 6'(i), slot_gen[i], 1'b1, i == last_hit);
            end
            default: expect_rsp(STS_OK, '0, '0, 1'b0, 1'b1);
        endcase
    endtask

    // Presents one request word and returns once it is accepted. When the next
    // gap is zero, valid stays high so the next word follows back to back.
    task automatic send_req(input t_req_word w);
        repeat (send_gap) @(posedge i_clk);
        in_word  <= w;
        in_valid <= 1'b1;
        valid_held = 1'b0;
        @(posedge i_clk);
        while (in_stall)
            @(posedge i_clk);
        predict_slot_table(w);
        send_gap = draw_wait(send_burst);
        if (send_gap != 0)
            in_valid <= 1'b0;
        else
            valid_held = 1'b1;
    endtask

    task automatic drain_responses();
        if (valid_held) begin
            in_valid <= 1'b0;
            valid_held = 1'b0;
        end
        while (pending_responses.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic report_mismatch(input t_rsp_word want, input t_rsp_word got,
                                   input bit unexpected);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            if (unexpected)
                $display("unexpected response: st=%0d idx=%0d gen=%0d flag=%0d last=%0d",
                         got.status, got.out_index, got.out_gen, got.flag, got.last);
            else
                $display("mismatch: exp st=%0d idx=%0d gen=%0d flag=%0d last=%0d, got st=%0d idx=%0d gen=%0d flag=%0d last=%0d",
                         want.status, want.out_index, want.out_gen, want.flag, want.last,
                         got.status, got.out_index, got.out_gen, got.flag, got.last);
        end
    endtask

    // Response checker and receiver stall generator.
    always @(posedge i_clk) begin : rsp_check
        t_rsp_word got;
        t_rsp_word want;
        if (i_rst_n) begin
            if (stall_left != 0) begin
                stall_left--;
                if (stall_left == 0)
                    out_stall <= 1'b0;
            end else if (out_valid) begin
                got = out_word;
                if (pending_responses.size() == 0) begin
                    report_mismatch(got, got, 1'b1);
                end else begin
                    want = pending_responses.pop_front();
                    if (got.status !== want.status || got.out_index !== want.out_index ||
                        got.out_gen !== want.out_gen || got.flag !== want.flag ||
                        got.last !== want.last)
                        report_mismatch(want, got, 1'b0);
                end
                stall_left = draw_wait(recv_burst);
                if (stall_left != 0)
                    out_stall <= 1'b1;
            end
        end
    end

    task automatic test_directed_basics();
        send_req(req_word(REQ_CHECK, 6'd0, 8'd0, 5'd0, 32'd0));
        send_req(req_word(REQ_ALLOC, 6'd0, 8'd0, 5'd0, 32'hFFFF_FFFF));
        send_req(req_word(REQ_ALLOC, 6'd63, 8'hFF, 5'd31, 32'h0));
        send_req(req_word(REQ_CHECK, 6'd0, 8'd0, 5'd0, 32'd0));
        send_req(req_word(REQ_CHECK, 6'd0, 8'hFF, 5'd0, 32'd0));
        send_req(req_word(REQ_TEST, 6'd0, 8'd0, 5'd31, 32'd0));
        send_req(req_word(REQ_CLEAR, 6'd0, 8'd0, 5'd31, 32'd0));
        send_req(req_word(REQ_TEST, 6'd0, 8'd0, 5'd31, 32'd0));
        send_req(req_word(REQ_SET, 6'd1, 8'd0, 5'd0, 32'd0));
        send_req(req_word(REQ_TEST, 6'd1, 8'd0, 5'd0, 32'd0));
        send_req(req_word(REQ_TEST, 6'd1, 8'd0, 5'd5, 32'd0));
        // Slot 0 lost bit 31, so this query finds nothing.
        send_req(req_word(REQ_MATCH, 6'd0, 8'd0, 5'd0, 32'h8000_0001));
        send_req(req_word(REQ_MATCH, 6'd0, 8'd0, 5'd0, 32'h0000_0001));
        send_req(req_word(REQ_MATCH, 6'd0, 8'd0, 5'd0, 32'h0));
        send_req(req_word(REQ_FREE, 6'd0, 8'd0, 5'd0, 32'd0));
        // The second free of the same handle is stale.
        send_req(req_word(REQ_FREE, 6'd0, 8'd0, 5'd0, 32'd0));
        send_req(req_word(REQ_SET, 6'd0, 8'd0, 5'd3, 32'd0));
        send_req(req_word(REQ_CLEAR, 6'd0, 8'd0, 5'd3, 32'd0));
        send_req(req_word(REQ_TEST, 6'd0, 8'd0, 5'd3, 32'd0));
        send_req(req_word(REQ_CHECK, 6'd0, 8'd1, 5'd0, 32'd0));
        send_req(req_word(REQ_ALLOC, 6'd0, 8'd0, 5'd0, 32'h5555_AAAA));
        send_req(req_word(REQ_CHECK, 6'd0, 8'd1, 5'd0, 32'd0));
        send_req(req_word(REQ_FREE, 6'd63, 8'd0, 5'd0, 32'd0));
        send_req(req_word(REQ_UNUSED, 6'd63, 8'hFF, 5'd31, 32'hFFFF_FFFF));
    endtask

    task automatic test_pool_exhaustion();
        int s;
        while (free_depth > 0)
            send_req(req_word(REQ_ALLOC, 6'($urandom), 8'($urandom), 5'($urandom), rand_mask()));
        send_req(req_word(REQ_ALLOC, 6'($urandom), 8'($urandom), 5'($urandom), $urandom));
        send_req(req_word(REQ_ALLOC, 6'($urandom), 8'($urandom), 5'($urandom), $urandom));
        // A zero query matches every slot, which gives the longest burst of words.
        send_req(req_word(REQ_MATCH, 6'($urandom), 8'($urandom), 5'($urandom), 32'h0));
        s = pick_live_slot();
        send_req(req_word(REQ_MATCH, 6'd0, 8'd0, 5'd0, slot_comps[s] & $urandom & $urandom));
        drain_responses();
        s = pick_live_slot();
        while (s >= 0) begin
            send_req(req_word(REQ_FREE, 6'(s), slot_gen[s], 5'($urandom), $urandom));
            if ($urandom_range(0, 7) == 0)
                send_req(req_word(REQ_FREE, 6'(s), slot_gen[s] - 8'd1, 5'd0, 32'd0));
            s = pick_live_slot();
        end
    endtask

    // Reallocating the top of the free stack drives one slot's generation up.
    task automatic test_generation_reuse();
        logic [5:0] s;
        logic [7:0] g;
        for (int n = 0; n < 80; n++) begin
            s = free_slots[free_depth - 1];
            send_req(req_word(REQ_ALLOC, 6'($urandom), 8'($urandom), 5'($urandom), rand_mask()));
            g = slot_gen[s];
            send_req(req_word(REQ_FREE, s, g, 5'($urandom), $urandom));
            if (n % 32 == 0)
                send_req(req_word(REQ_CHECK, s, g, 5'd0, 32'd0));
        end
    endtask

    task automatic test_random_traffic(input int count);
        int         s;
        int         pick;
        logic [7:0] g;
        logic [2:0] op;
        for (int n = 0; n < count; n++) begin
            s = pick_live_slot();
            pick = $urandom_range(0, 99);
            if (s < 0 && pick < 77)
                pick = 0;
            else if (live_count() > 48 && pick < 27)
                pick = 20;
            g = (s >= 0) ? slot_gen[s] : 8'd0;
            if (pick < 15) begin
                send_req(req_word(REQ_ALLOC, 6'($urandom), 8'($urandom), 5'($urandom),
                                  rand_mask()));
            end else if (pick < 27) begin
                send_req(req_word(REQ_FREE, 6'(s), g, 5'($urandom), $urandom));
            end else if (pick < 60) begin
                case ($urandom_range(0, 2))
                    0: op = REQ_SET;
                    1: op = REQ_CLEAR;
                    default: op = REQ_TEST;
                endcase
                send_req(req_word(op, 6'(s), g, 5'($urandom), $urandom));
            end else if (pick < 67) begin
                if ($urandom_range(0, 1) == 0)
                    g = g + 8'($urandom_range(1, 255));
                send_req(req_word(REQ_CHECK, 6'(s), g, 5'($urandom), $urandom));
            end else if (pick < 77) begin
                case ($urandom_range(0, 2))
                    0: send_req(req_word(REQ_MATCH, 6'($urandom), 8'($urandom), 5'($urandom),
                                         slot_comps[s] & $urandom & $urandom));
                    1: send_req(req_word(REQ_MATCH, 6'd0, 8'd0, 5'd0, 32'h0));
                    default: send_req(req_word(REQ_MATCH, 6'd0, 8'd0, 5'd0, rand_mask()));
                endcase
            end else begin
                send_req(req_word(3'($urandom), 6'($urandom), 8'($urandom), 5'($urandom),
                                  $urandom));
            end
        end
    endtask

    initial begin
        reset_slot_table();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_basics();
        drain_responses();
        test_pool_exhaustion();
        drain_responses();
        test_generation_reuse();
        test_random_traffic(120);
        drain_responses();
        repeat (2 * ENTITY_SLOTS + 16) @(posedge i_clk);
        if (pending_responses.size() != 0)
            $display("responses still expected at end: %0d", pending_responses.size());
        if (mismatch_count == 0 && pending_responses.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #30_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
